// ===== rtl/cpz_pkg.sv =====
// Package for the camera pan/zoom/clamp unit: beat types, datapath op codes,
// controller states and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpz_pkg;

  localparam int unsigned PIX_PER_UNIT = 32;

  localparam logic [1:0] CMD_PAN   = 2'd0;
  localparam logic [1:0] CMD_ZOOM  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [2:0] REG_CLAMP_EN = 3'd0;
  localparam logic [2:0] REG_WMIN_X   = 3'd1;
  localparam logic [2:0] REG_WMAX_X   = 3'd2;
  localparam logic [2:0] REG_WMIN_Y   = 3'd3;
  localparam logic [2:0] REG_WMAX_Y   = 3'd4;
  localparam logic [2:0] REG_ZOOM_MIN = 3'd5;
  localparam logic [2:0] REG_ZOOM_MAX = 3'd6;
  localparam logic [2:0] REG_VIEWPORT = 3'd7;

  localparam logic [15:0] ZOOM_ONE       = 16'd256;
  localparam logic [15:0] ZOOM_MIN_RST   = 16'd64;
  localparam logic [15:0] ZOOM_MAX_RST   = 16'd1024;
  localparam logic [31:0] VIEWPORT_RST   = 32'd39322400;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic [15:0]        zoom_factor;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        zoom_now;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
  } out_beat_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PAN,
    OP_ZPROD,
    OP_ZSAT,
    OP_ZX_SET,
    OP_ZX_APPLY,
    OP_ZY_SET,
    OP_ZY_APPLY,
    OP_CX_SET,
    OP_CX_APPLY,
    OP_CY_SET,
    OP_CY_APPLY,
    OP_QX_SET,
    OP_QX_APPLY,
    OP_QY_SET,
    OP_QY_APPLY,
    OP_DIV_GO,
    OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PAN,
    ST_ZPROD,
    ST_ZSAT,
    ST_ZX_SET, ST_ZX_GO, ST_ZX_WAIT,
    ST_ZY_SET, ST_ZY_GO, ST_ZY_WAIT,
    ST_CX_SET, ST_CX_GO, ST_CX_WAIT,
    ST_CY_SET, ST_CY_GO, ST_CY_WAIT,
    ST_QX_SET, ST_QX_GO, ST_QX_WAIT,
    ST_QY_SET, ST_QY_GO, ST_QY_WAIT,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic       clamp_en;
    logic       div_done;
    logic       out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/cpz_div.sv =====
// Iterative signed-by-unsigned divider, round half away from zero, one
// quotient bit per cycle. Uses no package items.
`timescale 1ns / 1ps
`default_nettype none
module cpz_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic [31:0]        den_i,
  output logic                    done_o,
  output logic signed [63:0]      quot_o
);
  logic [63:0] mag_q, mag_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [63:0] abs_num;

  always_comb begin
    abs_num = num_i[63] ? (64'd0 - 64'(num_i)) : 64'(num_i);
    rem_sh  = {rem_q, mag_q[63]};
    rem_sub = rem_sh - {1'b0, den_q};
    mag_d   = mag_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      mag_d  = abs_num + {33'd0, den_i[31:1]};
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[63];
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_d = rem_sub[31:0];
        mag_d = {mag_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        mag_d = {mag_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule
`default_nettype wire

// ===== rtl/cpz_ctrl.sv =====
// Sequencer of the camera unit: walks each command through its datapath
// ops. Depends on cpz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpz_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cpz_pkg::dp_status_t st_i,
  output cpz_pkg::dp_op_e         op_o
);
  import cpz_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PAN; // cmd decoded next cycle
      ST_PAN: begin
        case (st_i.cmd)
          CMD_PAN:   state_d = st_i.clamp_en ? ST_CX_SET : ST_FIN;
          CMD_ZOOM:  state_d = ST_ZPROD;
          CMD_QUERY: state_d = ST_QX_SET;
          default:   state_d = ST_FIN;
        endcase
      end
      ST_ZPROD:   state_d = ST_ZSAT;
      ST_ZSAT:    state_d = ST_ZX_SET;
      ST_ZX_SET:  state_d = ST_ZX_GO;
      ST_ZX_GO:   state_d = ST_ZX_WAIT;
      ST_ZX_WAIT: if (st_i.div_done) state_d = ST_ZY_SET;
      ST_ZY_SET:  state_d = ST_ZY_GO;
      ST_ZY_GO:   state_d = ST_ZY_WAIT;
      ST_ZY_WAIT: if (st_i.div_done) state_d = st_i.clamp_en ? ST_CX_SET : ST_FIN;
      ST_CX_SET:  state_d = ST_CX_GO;
      ST_CX_GO:   state_d = ST_CX_WAIT;
      ST_CX_WAIT: if (st_i.div_done) state_d = ST_CY_SET;
      ST_CY_SET:  state_d = ST_CY_GO;
      ST_CY_GO:   state_d = ST_CY_WAIT;
      ST_CY_WAIT: if (st_i.div_done) state_d = ST_FIN;
      ST_QX_SET:  state_d = ST_QX_GO;
      ST_QX_GO:   state_d = ST_QX_WAIT;
      ST_QX_WAIT: if (st_i.div_done) state_d = ST_QY_SET;
      ST_QY_SET:  state_d = ST_QY_GO;
      ST_QY_GO:   state_d = ST_QY_WAIT;
      ST_QY_WAIT: if (st_i.div_done) state_d = ST_FIN;
      ST_FIN:     if (!st_i.out_busy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      ST_PAN:     if (st_i.cmd == CMD_PAN) op_o = OP_PAN;
      ST_ZPROD:   op_o = OP_ZPROD;
      ST_ZSAT:    op_o = OP_ZSAT;
      ST_ZX_SET:  op_o = OP_ZX_SET;
      ST_ZY_SET:  op_o = OP_ZY_SET;
      ST_CX_SET:  op_o = OP_CX_SET;
      ST_CY_SET:  op_o = OP_CY_SET;
      ST_QX_SET:  op_o = OP_QX_SET;
      ST_QY_SET:  op_o = OP_QY_SET;
      ST_ZX_GO, ST_ZY_GO, ST_CX_GO, ST_CY_GO, ST_QX_GO, ST_QY_GO: op_o = OP_DIV_GO;
      ST_ZX_WAIT: if (st_i.div_done) op_o = OP_ZX_APPLY;
      ST_ZY_WAIT: if (st_i.div_done) op_o = OP_ZY_APPLY;
      ST_CX_WAIT: if (st_i.div_done) op_o = OP_CX_APPLY;
      ST_CY_WAIT: if (st_i.div_done) op_o = OP_CY_APPLY;
      ST_QX_WAIT: if (st_i.div_done) op_o = OP_QX_APPLY;
      ST_QY_WAIT: if (st_i.div_done) op_o = OP_QY_APPLY;
      ST_FIN:     if (!st_i.out_busy) op_o = OP_OUT;
      default:    op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpz_dp.sv =====
// Datapath of the camera unit: config registers, camera state, multipliers,
// shared divider and output register. Depends on cpz_pkg and cpz_div.
`timescale 1ns / 1ps
`default_nettype none
module cpz_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cpz_pkg::in_beat_t  in_data_i,
  input  wire cpz_pkg::dp_op_e    op_i,
  output cpz_pkg::dp_status_t     st_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cpz_pkg::out_beat_t      out_data_o
);
  import cpz_pkg::*;

  // config
  logic               clamp_en_q;
  logic signed [31:0] wmin_x_q, wmax_x_q, wmin_y_q, wmax_y_q;
  logic [15:0]        zmin_q, zmax_q;
  logic [31:0]        vp_q;

  // state and work registers
  logic signed [31:0] cam_x_q, cam_y_q, wx_q, wy_q;
  logic [15:0]        zoom_q, nz_q, old_q;
  logic [1:0]         cmd_q;
  logic signed [31:0] ax_q, ay_q;
  logic [15:0]        fac_q;
  logic [31:0]        prod_q;
  logic signed [63:0] num_q;
  logic [31:0]        den_q;
  logic               out_valid_q;
  out_beat_t          out_q;

  logic               div_done;
  logic signed [63:0] div_quot;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  cpz_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(op_i == OP_DIV_GO),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // combinational helpers
  logic [24:0]        nz_raw;
  logic [15:0]        nz_sel;
  logic signed [16:0] zdiff;
  logic signed [32:0] dpos;
  logic signed [40:0] dpos_s;
  logic signed [57:0] mv_prod;
  logic [15:0]        zmin_eff;
  logic [15:0]        dim;
  logic signed [33:0] qoff;
  logic signed [31:0] pix;
  logic signed [31:0] cam_sel, wmin_sel, wmax_sel;
  logic signed [40:0] half, lo, hi, pc;
  logic signed [64:0] q65;

  always_comb begin
    nz_raw = 25'((prod_q + 32'd128) >> 8);
    nz_sel = nz_raw[15:0];
    if (nz_raw < {9'd0, zmin_q}) nz_sel = zmin_q;
    if ((nz_raw >= {9'd0, zmin_q}) && (nz_raw > {9'd0, zmax_q})) nz_sel = zmax_q;
    if ((nz_raw < {9'd0, zmin_q}) && (zmin_q > zmax_q)) nz_sel = zmax_q;
    if (nz_sel == 16'd0) nz_sel = 16'd1;

    zdiff   = $signed({1'b0, nz_q}) - $signed({1'b0, old_q});
    cam_sel = (op_i == OP_ZY_SET || op_i == OP_CY_SET || op_i == OP_CY_APPLY) ?
              cam_y_q : cam_x_q;
    dpos    = $signed({(op_i == OP_ZY_SET) ? ay_q[31] : ax_q[31],
                       (op_i == OP_ZY_SET) ? ay_q : ax_q}) -
              $signed({cam_sel[31], cam_sel});
    dpos_s  = {dpos, 8'd0};
    mv_prod = dpos_s * zdiff;

    zmin_eff = (zmin_q == 16'd0) ? 16'd1 : zmin_q;
    dim      = (op_i == OP_CY_SET || op_i == OP_QY_SET) ? vp_q[31:16] : vp_q[15:0];
    pix      = (op_i == OP_QY_SET) ? ay_q : ax_q;
    qoff     = $signed({{2{pix[31]}}, pix}) - $signed({3'd0, dim, 15'd0});

    wmin_sel = (op_i == OP_CY_APPLY) ? wmin_y_q : wmin_x_q;
    wmax_sel = (op_i == OP_CY_APPLY) ? wmax_y_q : wmax_x_q;
    half     = div_quot[40:0];
    lo       = $signed({{9{wmin_sel[31]}}, wmin_sel}) + half;
    hi       = $signed({{9{wmax_sel[31]}}, wmax_sel}) - half;
    pc       = $signed({{9{cam_sel[31]}}, cam_sel});
    if (pc < lo) pc = lo;
    if (pc > hi) pc = hi;

    q65 = $signed({div_quot[63], div_quot});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_en_q  <= 1'b0;
      wmin_x_q    <= 32'sh8000_0000;
      wmax_x_q    <= 32'sh7FFF_FFFF;
      wmin_y_q    <= 32'sh8000_0000;
      wmax_y_q    <= 32'sh7FFF_FFFF;
      zmin_q      <= ZOOM_MIN_RST;
      zmax_q      <= ZOOM_MAX_RST;
      vp_q        <= VIEWPORT_RST;
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      zoom_q      <= ZOOM_ONE;
      cmd_q       <= CMD_PAN;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CLAMP_EN: clamp_en_q <= cfg_wdata_i[0];
          REG_WMIN_X:   wmin_x_q   <= cfg_wdata_i;
          REG_WMAX_X:   wmax_x_q   <= cfg_wdata_i;
          REG_WMIN_Y:   wmin_y_q   <= cfg_wdata_i;
          REG_WMAX_Y:   wmax_y_q   <= cfg_wdata_i;
          REG_ZOOM_MIN: zmin_q     <= cfg_wdata_i[15:0];
          REG_ZOOM_MAX: zmax_q     <= cfg_wdata_i[15:0];
          REG_VIEWPORT: vp_q       <= cfg_wdata_i;
          default:      ;
        endcase
      end
      // a new beat may load in the same cycle the old one leaves
      if (op_i == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_LOAD:     cmd_q <= in_data_i.cmd;
        OP_PAN: begin
          cam_x_q <= sat32(65'(ax_q) + 65'(cam_x_q));
          cam_y_q <= sat32(65'(ay_q) + 65'(cam_y_q));
        end
        OP_ZX_APPLY: cam_x_q <= sat32(65'(cam_x_q) + q65);
        OP_ZY_APPLY: begin
          cam_y_q <= sat32(65'(cam_y_q) + q65);
          zoom_q  <= nz_q;
        end
        OP_CX_APPLY: cam_x_q <= sat32(65'(pc));
        OP_CY_APPLY: cam_y_q <= sat32(65'(pc));
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        ax_q  <= in_data_i.arg_x;
        ay_q  <= in_data_i.arg_y;
        fac_q <= in_data_i.zoom_factor;
        wx_q  <= '0;
        wy_q  <= '0;
      end
      OP_ZPROD: begin
        prod_q <= zoom_q * fac_q;
        old_q  <= zoom_q;
      end
      OP_ZSAT: nz_q <= nz_sel;
      OP_ZX_SET, OP_ZY_SET: begin
        num_q <= 64'(mv_prod);
        den_q <= old_q * nz_q;
      end
      OP_CX_SET, OP_CY_SET: begin
        num_q <= $signed({25'd0, dim, 23'd0});
        den_q <= 32'(PIX_PER_UNIT) * {16'd0, zmin_eff};
      end
      OP_QX_SET, OP_QY_SET: begin
        num_q <= 64'($signed({qoff, 8'd0}));
        den_q <= 32'(PIX_PER_UNIT) * {16'd0, zoom_q};
      end
      OP_QX_APPLY: wx_q <= sat32(65'(cam_x_q) + q65);
      OP_QY_APPLY: wy_q <= sat32(65'(cam_y_q) - q65);
      OP_OUT: begin
        out_q.pos_x    <= cam_x_q;
        out_q.pos_y    <= cam_y_q;
        out_q.zoom_now <= zoom_q;
        out_q.world_x  <= wx_q;
        out_q.world_y  <= wy_q;
      end
      default: ;
    endcase
  end

  assign st_o.cmd      = cmd_q;
  assign st_o.clamp_en = clamp_en_q;
  assign st_o.div_done = div_done;
  assign st_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;

endmodule
`default_nettype wire

// ===== rtl/camera_pan_zoom_clamp_unit.sv =====
// Top level of the 2D camera pan/zoom/clamp unit: controller plus datapath.
// Depends on cpz_pkg, cpz_ctrl, cpz_dp (and cpz_div below it).
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i) takes one command beat:
//    pan by delta, zoom about an anchor, or screen-to-world query.
//  - Output channel (out_valid_o/out_ready_i/out_data_o) returns one beat per
//    command: position and zoom after it, plus the mapped point for queries.
//  - cfg_we_i/cfg_idx_i/cfg_wdata_i write the config registers;
//    write only while the unit is idle.
// Sequence: the accepted beat loads, the command is decoded (a pan is
// applied there), then these steps run before the output load:
//  - pan or unused command: none; pan with clamping on: X/Y clamp divides
//  - zoom: product, saturation, X/Y zoom divides, then clamp divides if on
//  - query: X/Y query divides
// Each divide uses the shared bit-serial divider: setup, start, one iteration
// per bit of the 64-bit quotient, and the update. One command is in flight at
// a time; a new beat can be taken in the cycle after the output beat loads.
// Reset: camera at origin, zoom 1.0, config registers at their defaults.
// A stalled receiver keeps the output register full; the next command is
// still taken and computed, then waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module camera_pan_zoom_clamp_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cpz_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cpz_pkg::out_beat_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i
);
  import cpz_pkg::*;

  dp_op_e     op;
  dp_status_t st;

  cpz_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .op_o      (op)
  );

  cpz_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .op_i       (op),
    .st_o       (st),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== rtl/cpz_checker.sv =====
// Port-level checks for the camera unit, bound to the top level.
// Depends on cpz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpz_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire cpz_pkg::out_beat_t out_data_o
);
  import cpz_pkg::*;

  // a held output beat does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // one command at a time: accepting a beat drops ready
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  // zoom never reported as zero
  a_zoom_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.zoom_now != 16'd0)
    else $error("zero zoom on output");

  // no result without a command in between
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && in_ready_o |=> !out_valid_o)
    else $error("result appeared without a command");

endmodule

bind camera_pan_zoom_clamp_unit cpz_checker u_cpz_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

// ===== sim/tb_camera_pan_zoom_clamp_unit.sv =====
// Self-checking bench for camera_pan_zoom_clamp_unit: directed table, then random
// pan/zoom/query/unused beats, scored against an in-bench camera model or typed-in rows.
// Depends on cpz_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_camera_pan_zoom_clamp_unit;
  import cpz_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_beat_t in_data_i;
  out_beat_t out_data_o;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  camera_pan_zoom_clamp_unit DUT (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Camera model state and shadow config
  logic        m_clamp;
  longint      m_wminx, m_wmaxx, m_wminy, m_wmaxy;
  logic [15:0] m_zmin, m_zmax;
  logic [31:0] m_view;
  longint      m_cx, m_cy;
  logic [15:0] m_zoom;

  out_beat_t pending_beats[$];
  int errors = 0;
  int n_mism = 0;
  int idle_pct = 32;     // sender/receiver idle odds, 0 during quiet stretch
  bit hold_rx = 0;       // long receiver hold-off request
  int hold_len = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round to nearest, halves away from zero
  function automatic longint rdiv(longint num, longint unsigned den);
    longint unsigned mag, q;
    if (den == 0) den = 1;
    mag = (num < 0) ? longint'(0) - num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_one(longint p, longint lo_b, longint hi_b, longint dim);
    longint unsigned zm;
    longint half;
    zm = (m_zmin == 0) ? 1 : m_zmin;
    half = rdiv(dim <<< 23, PIX_PER_UNIT * zm);
    if (p < lo_b + half) p = lo_b + half;
    if (p > hi_b - half) p = hi_b - half;
    return sat32(p);
  endfunction

  function automatic void clamp_cam();
    if (!m_clamp) return;
    m_cx = clamp_one(m_cx, m_wminx, m_wmaxx, m_view[15:0]);
    m_cy = clamp_one(m_cy, m_wminy, m_wmaxy, m_view[31:16]);
  endfunction

  function automatic void model_reset();
    m_clamp = 0;
    m_wminx = -64'sd2147483648; m_wmaxx = 64'sd2147483647;
    m_wminy = -64'sd2147483648; m_wmaxy = 64'sd2147483647;
    m_zmin = ZOOM_MIN_RST; m_zmax = ZOOM_MAX_RST; m_view = VIEWPORT_RST;
    m_cx = 0; m_cy = 0; m_zoom = ZOOM_ONE;
  endfunction

  function automatic out_beat_t camera_step(in_beat_t b);
    out_beat_t r;
    longint ax, ay, wx, wy, diff, nz;
    longint unsigned den;
    ax = b.arg_x; ay = b.arg_y; wx = 0; wy = 0;
    case (b.cmd)
      CMD_PAN: begin
        m_cx = sat32(m_cx + ax);
        m_cy = sat32(m_cy + ay);
        clamp_cam();
      end
      CMD_ZOOM: begin
        nz = (longint'(m_zoom) * b.zoom_factor + 128) >>> 8;
        if (nz < m_zmin) nz = m_zmin;
        if (nz > m_zmax) nz = m_zmax;
        if (nz == 0) nz = 1;
        diff = nz - m_zoom;
        den = longint'(m_zoom) * nz;
        m_zoom = nz[15:0];
        m_cx = sat32(m_cx + rdiv((ax - m_cx) * 256 * diff, den));
        m_cy = sat32(m_cy + rdiv((ay - m_cy) * 256 * diff, den));
        clamp_cam();
      end
      CMD_QUERY: begin
        den = PIX_PER_UNIT * longint'(m_zoom);
        wx = sat32(m_cx + rdiv((ax - (longint'(m_view[15:0]) <<< 15)) * 256, den));
        wy = sat32(m_cy - rdiv((ay - (longint'(m_view[31:16]) <<< 15)) * 256, den));
      end
      default: ;
    endcase
    r.pos_x = m_cx[31:0]; r.pos_y = m_cy[31:0]; r.zoom_now = m_zoom;
    r.world_x = wx[31:0]; r.world_y = wy[31:0];
    return r;
  endfunction

  function automatic void shadow_cfg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_CLAMP_EN: m_clamp = v[0];
      REG_WMIN_X:   m_wminx = longint'(signed'(v));
      REG_WMAX_X:   m_wmaxx = longint'(signed'(v));
      REG_WMIN_Y:   m_wminy = longint'(signed'(v));
      REG_WMAX_Y:   m_wmaxy = longint'(signed'(v));
      REG_ZOOM_MIN: m_zmin = v[15:0];
      REG_ZOOM_MAX: m_zmax = v[15:0];
      REG_VIEWPORT: m_view = v;
      default: ;
    endcase
  endfunction

  // Config write: only called while idle; the write strobe drops before the task returns
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    shadow_cfg(idx, v);
    @(negedge clk_i);
  endtask

  // Wait until all results are in, then let the divider settle
  task automatic drain();
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // Offer one beat; valid held until accepted. The unit stays busy after a beat at
  // least until the closing wait ends, so that wait costs no throughput.
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    in_valid_i <= 1; in_data_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_beats.push_back(camera_step(b));
    @(negedge clk_i);
    in_valid_i <= 0;
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_ready_i <= 0;
    end else if (hold_rx) begin
      hold_len <= 3000;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Scoreboard: each output beat against the oldest prediction
  always @(posedge clk_i) begin
    out_beat_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        errors++;
        if (n_mism++ < 10) $display("unexpected output beat %h", out_data_o);
      end else begin
        exp_b = pending_beats.pop_front();
        if (exp_b.pos_x !== out_data_o.pos_x || exp_b.pos_y !== out_data_o.pos_y ||
            exp_b.zoom_now !== out_data_o.zoom_now ||
            exp_b.world_x !== out_data_o.world_x ||
            exp_b.world_y !== out_data_o.world_y) begin
          errors++;
          if (n_mism++ < 10)
            $display("mismatch exp pos %h %h z %h w %h %h / got pos %h %h z %h w %h %h",
              exp_b.pos_x, exp_b.pos_y, exp_b.zoom_now, exp_b.world_x, exp_b.world_y,
              out_data_o.pos_x, out_data_o.pos_y, out_data_o.zoom_now,
              out_data_o.world_x, out_data_o.world_y);
        end
      end
    end
  end

  // Directed rows: beat plus optional typed-in expectation
  typedef struct {
    in_beat_t  b;
    bit        has_exp;
    out_beat_t e;
  } dir_row_t;

  function automatic in_beat_t mk(logic [1:0] c, int x, int y, logic [15:0] f);
    in_beat_t b;
    b.cmd = c; b.arg_x = x; b.arg_y = y; b.zoom_factor = f;
    return b;
  endfunction

  function automatic out_beat_t ob(int px, int py, logic [15:0] z, int wx, int wy);
    out_beat_t o;
    o.pos_x = px; o.pos_y = py; o.zoom_now = z; o.world_x = wx; o.world_y = wy;
    return o;
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int sel;
    sel = $urandom_range(99);
    b.cmd = (sel < 40) ? CMD_PAN : (sel < 75) ? CMD_ZOOM : (sel < 97) ? CMD_QUERY : CMD_NOP;
    b.arg_x = $urandom; b.arg_y = $urandom; b.zoom_factor = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      // mostly modest values so clamping and zoom stay in play
      b.arg_x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      b.arg_y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      b.zoom_factor = 16'($urandom_range(128, 512));
    end
    return b;
  endfunction

  task automatic random_cfg();
    int lo;
    write_reg(REG_CLAMP_EN, $urandom);
    lo = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh1000_0000;
    write_reg(REG_WMIN_X, ($urandom_range(9) == 0) ? $urandom : lo);
    write_reg(REG_WMAX_X, ($urandom_range(9) == 0) ? $urandom : lo + $urandom_range(0, 32'h1FFF_FFFF));
    lo = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh1000_0000;
    write_reg(REG_WMIN_Y, ($urandom_range(9) == 0) ? $urandom : lo);
    write_reg(REG_WMAX_Y, ($urandom_range(9) == 0) ? $urandom : lo + $urandom_range(0, 32'h1FFF_FFFF));
    write_reg(REG_ZOOM_MIN, ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 256));
    write_reg(REG_ZOOM_MAX, ($urandom_range(9) == 0) ? $urandom : $urandom_range(200, 4096));
    write_reg(REG_VIEWPORT, ($urandom_range(9) == 0) ? $urandom :
              {16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))});
  endtask

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    rst_ni = 0; in_valid_i = 0; in_data_i = '0;
    cfg_we_i = 0; cfg_idx_i = REG_CLAMP_EN; cfg_wdata_i = '0;
    model_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
    @(negedge clk_i);

    // after reset: unused command reports the reset state
    r.b = mk(CMD_NOP, -1, -1, 16'hFFFF); r.has_exp = 1; r.e = ob(0, 0, ZOOM_ONE, 0, 0); rows.push_back(r);
    // center pixel of 800x600 maps to origin
    r.b = mk(CMD_QUERY, 400 << 16, 300 << 16, 0); r.e = ob(0, 0, ZOOM_ONE, 0, 0); rows.push_back(r);
    r.b = mk(CMD_PAN, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    r.e = ob(32'h7FFF_FFFF, 32'h8000_0000, ZOOM_ONE, 0, 0); rows.push_back(r);
    // saturation on both ends
    r.b = mk(CMD_PAN, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    r.e = ob(32'h7FFF_FFFF, 32'h8000_0000, ZOOM_ONE, 0, 0); rows.push_back(r);
    r.has_exp = 0;
    r.b = mk(CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0); rows.push_back(r);
    r.b = mk(CMD_PAN, 32'h8000_0000, 32'h7FFF_FFFF, 0); rows.push_back(r);
    // zoom factor zero goes to zoom_min, max factor to zoom_max
    r.b = mk(CMD_ZOOM, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000); rows.push_back(r);
    r.b = mk(CMD_ZOOM, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF); rows.push_back(r);
    r.b = mk(CMD_ZOOM, 0, 0, 16'd256); rows.push_back(r);
    r.b = mk(CMD_ZOOM, 12345, -54321, 16'd128); rows.push_back(r);
    r.b = mk(CMD_QUERY, 0, 0, 16'hFFFF); rows.push_back(r);
    r.b = mk(CMD_QUERY, -1, 32'h7FFF_FFFF, 0); rows.push_back(r);
    foreach (rows[i]) begin
      send_beat(rows[i].b);
      if (rows[i].has_exp) pending_beats[pending_beats.size() - 1] = rows[i].e;
    end
    drain();

    // clamp on, crossed bounds (upper wins), zoom limits crossed, zero zoom_min
    write_reg(REG_CLAMP_EN, 1);
    write_reg(REG_WMIN_X, 32'h0010_0000); write_reg(REG_WMAX_X, 32'h0000_0000);
    write_reg(REG_WMIN_Y, 32'h8000_0000); write_reg(REG_WMAX_Y, 32'h7FFF_FFFF);
    write_reg(REG_ZOOM_MIN, 32'd0); write_reg(REG_ZOOM_MAX, 32'd0);
    write_reg(REG_VIEWPORT, 32'hFFFF_FFFF);
    send_beat(mk(CMD_PAN, 5, -5, 0));
    send_beat(mk(CMD_ZOOM, 100, 100, 16'd0));
    send_beat(mk(CMD_ZOOM, 100, 100, 16'hFFFF));
    drain();
    write_reg(REG_ZOOM_MIN, 32'h0000_FFFF); write_reg(REG_ZOOM_MAX, 32'd1);
    send_beat(mk(CMD_ZOOM, -100, 7, 16'd300));
    send_beat(mk(CMD_QUERY, 0, 0, 0));
    send_beat(mk(CMD_NOP, 0, 0, 0));
    drain();

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      random_cfg();
      for (int k = 0; k < 100; k++) begin
        if (ph == 3 && k == 10) hold_rx = 1;   // long receiver hold-off
        if (ph == 3 && k == 11) hold_rx = 0;
        if (ph == 5) idle_pct = 0;             // stretch with no idling
        else idle_pct = 32;
        if (ph == 7 && k == 50)                // sender waits for all results
          while (pending_beats.size() != 0) @(negedge clk_i);
        send_beat(rand_beat());
      end
      drain();
    end

    if (errors == 0 && pending_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
